[rtl/tecq_pkg.sv]
// ----------------------------------------------------------------------------
// tecq_pkg - shared types and constants for the touch event coalescing queue
// Request and result layouts, the slot entry format and sequencer states.
// ----------------------------------------------------------------------------
package tecq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int LEVEL_OUT_W = 5;
	localparam int CNT_W       = 32;

	// operation codes
	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_CANCEL = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	// report phases
	localparam logic [1:0] PH_PRESS   = 2'd0;
	localparam logic [1:0] PH_MOVE    = 2'd1;
	localparam logic [1:0] PH_RELEASE = 2'd2;
	localparam logic [1:0] PH_OTHER   = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  phase;
		logic [7:0]  contact_id;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [7:0]  pressure;
		logic [7:0]  major_axis;
		logic [7:0]  minor_axis;
	} request_t;

	typedef struct packed {
		logic                   accepted;
		logic [LEVEL_OUT_W-1:0] level_before;
		logic                   head_valid;
		logic [1:0]             head_phase;
		logic [7:0]             head_id;
		logic [15:0]            head_x;
		logic [15:0]            head_y;
		logic [7:0]             head_pressure;
		logic [7:0]             head_major;
		logic [7:0]             head_minor;
		logic [CNT_W-1:0]       dropped_total;
		logic [CNT_W-1:0]       coalesced_total;
	} result_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [7:0]  id;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  pressure;
		logic [7:0]  major;
		logic [7:0]  minor;
	} entry_t;

	typedef struct packed {
		logic                   done;
		logic                   accepted;
		logic                   inc_drop;
		logic                   inc_coal;
		logic                   inc_queued;
		logic                   clr_cnt;
		logic [LEVEL_OUT_W-1:0] level_before;
		logic                   head_valid;
		entry_t                 head;
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_BACK,
		ST_SEARCH,
		ST_SHIFT,
		ST_HEAD,
		ST_DONE
	} state_t;

endpackage

[rtl/tecq_ram.sv]
// ----------------------------------------------------------------------------
// tecq_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tecq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/tecq_ctrl.sv]
// ----------------------------------------------------------------------------
// tecq_ctrl - queue sequencer
// Walks the slot RAM one entry a cycle for the room check, the move search
// and the shift, then reads the head entry and reports the outcome.
// ----------------------------------------------------------------------------
module tecq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  tecq_pkg::request_t           request,
	output logic                         busy,
	output logic                         we,
	output logic [tecq_pkg::IDX_W-1:0]   wr_addr,
	output tecq_pkg::entry_t             wr_data,
	output logic [tecq_pkg::IDX_W-1:0]   rd_addr,
	input  tecq_pkg::entry_t             rd_data,
	output tecq_pkg::status_t            st
);

	import tecq_pkg::*;

	function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] head,
	                                             input logic [LVL_W-1:0] logical);
		logic [LVL_W:0] sum;
		sum = {{(LVL_W + 1 - IDX_W){1'b0}}, head} + {1'b0, logical};
		if (sum >= (LVL_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (LVL_W + 1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [LEVEL_OUT_W-1:0] level_out(input logic [LVL_W-1:0] fill);
		logic [LVL_W+LEVEL_OUT_W-1:0] ext;
		ext = {{LEVEL_OUT_W{1'b0}}, fill};
		return ext[LEVEL_OUT_W-1:0];
	endfunction

	state_t                 state_q, state_d;
	request_t               req_q;
	logic [IDX_W-1:0]       head_q;
	logic [LVL_W-1:0]       fill_q;
	logic [LVL_W-1:0]       cnt_q;
	logic [LVL_W-1:0]       moves_q;
	logic [LVL_W-1:0]       pidx_q;
	logic                   pend_q;
	logic                   more_q;
	logic [LEVEL_OUT_W-1:0] lvl_q;
	logic                   acc_q, drop_q, coal_q, queued_q, clr_q;

	entry_t           ent_new;
	logic [LVL_W-1:0] back_l;
	logic             full;
	logic             rd_is_move;
	logic             press_tight;
	logic             drop_room;
	logic             scan_done;
	logic             back_coalesce;
	logic             req_evicts;
	logic             search_found;
	logic             search_fail;
	logic             shift_done;

	assign ent_new = '{phase: req_q.phase, id: req_q.contact_id, x: req_q.x_pos,
	                   y: req_q.y_pos, pressure: req_q.pressure,
	                   major: req_q.major_axis, minor: req_q.minor_axis};

	assign back_l        = fill_q - LVL_W'(1);
	assign full          = (fill_q == LVL_W'(QUEUE_DEPTH));
	assign rd_is_move    = (rd_data.phase == PH_MOVE);
	assign press_tight   = (request.phase == PH_PRESS) &&
	                       (({1'b0, fill_q} + (LVL_W + 1)'(1)) >= (LVL_W + 1)'(QUEUE_DEPTH));
	// room = depth - fill + moves; too tight when room <= 1
	assign drop_room     = (({1'b0, moves_q} + (LVL_W + 1)'(QUEUE_DEPTH)) <=
	                        ({1'b0, fill_q} + (LVL_W + 1)'(1)));
	assign scan_done     = (cnt_q == fill_q) && !pend_q;
	assign back_coalesce = (req_q.phase == PH_MOVE) && rd_is_move;
	assign req_evicts    = (req_q.phase == PH_PRESS) || (req_q.phase == PH_RELEASE);
	assign search_found  = pend_q && rd_is_move;
	assign search_fail   = !more_q && !search_found;
	assign shift_done    = (cnt_q == fill_q) && !pend_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (request.func == FUNC_PUSH) begin
						state_d = press_tight ? ST_SCAN : ST_PLACE;
					end else begin
						state_d = ST_HEAD;
					end
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = drop_room ? ST_HEAD : ST_PLACE;
				end
			end
			ST_PLACE:  state_d = full ? ST_BACK : ST_HEAD;
			ST_BACK: begin
				if (!back_coalesce && req_evicts) begin
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_HEAD;
				end
			end
			ST_SEARCH: begin
				if (search_found) begin
					state_d = ST_SHIFT;
				end else if (search_fail) begin
					state_d = ST_HEAD;
				end
			end
			ST_SHIFT: begin
				if (shift_done) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD:   state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// RAM control and status
	always_comb begin
		rd_addr = ring_at(head_q, cnt_q);
		we      = 1'b0;
		wr_addr = ring_at(head_q, back_l);
		wr_data = ent_new;
		st      = '0;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_PLACE: begin
				if (full) begin
					rd_addr = ring_at(head_q, back_l);
				end else begin
					we      = 1'b1;
					wr_addr = ring_at(head_q, fill_q);
				end
			end
			ST_BACK: begin
				we = back_coalesce;
			end
			ST_SHIFT: begin
				if (pend_q) begin
					we      = 1'b1;
					wr_addr = ring_at(head_q, pidx_q - LVL_W'(1));
					wr_data = rd_data;
				end else if (shift_done) begin
					we = 1'b1;
				end
			end
			ST_HEAD: begin
				rd_addr = head_q;
			end
			ST_DONE: begin
				st.done         = 1'b1;
				st.accepted     = acc_q;
				st.inc_drop     = drop_q;
				st.inc_coal     = coal_q;
				st.inc_queued   = queued_q;
				st.clr_cnt      = clr_q;
				st.level_before = lvl_q;
				st.head_valid   = (fill_q != '0);
				st.head         = (fill_q != '0) ? rd_data : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			fill_q   <= '0;
			cnt_q    <= '0;
			moves_q  <= '0;
			pidx_q   <= '0;
			pend_q   <= 1'b0;
			more_q   <= 1'b0;
			lvl_q    <= '0;
			acc_q    <= 1'b0;
			drop_q   <= 1'b0;
			coal_q   <= 1'b0;
			queued_q <= 1'b0;
			clr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q    <= request;
						lvl_q    <= level_out(fill_q);
						acc_q    <= 1'b0;
						drop_q   <= 1'b0;
						coal_q   <= 1'b0;
						queued_q <= 1'b0;
						clr_q    <= 1'b0;
						cnt_q    <= '0;
						moves_q  <= '0;
						pend_q   <= 1'b0;
						case (request.func)
							FUNC_POP: begin
								if (fill_q != '0) begin
									head_q <= ring_at(head_q, LVL_W'(1));
									fill_q <= fill_q - LVL_W'(1);
								end
							end
							FUNC_CANCEL: begin
								head_q <= '0;
								fill_q <= '0;
							end
							FUNC_CLEAR: begin
								head_q <= '0;
								fill_q <= '0;
								clr_q  <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// count queued moves, one read in flight
					pend_q <= (cnt_q != fill_q);
					if (cnt_q != fill_q) begin
						cnt_q <= cnt_q + LVL_W'(1);
					end
					if (pend_q && rd_is_move) begin
						moves_q <= moves_q + LVL_W'(1);
					end
					if (scan_done && drop_room) begin
						drop_q <= 1'b1;
					end
				end
				ST_PLACE: begin
					if (!full) begin
						fill_q   <= fill_q + LVL_W'(1);
						acc_q    <= 1'b1;
						queued_q <= 1'b1;
					end
				end
				ST_BACK: begin
					if (back_coalesce) begin
						acc_q  <= 1'b1;
						coal_q <= 1'b1;
					end else if (req_evicts) begin
						cnt_q  <= back_l;
						more_q <= 1'b1;
						pend_q <= 1'b0;
					end else begin
						drop_q <= 1'b1;
					end
				end
				ST_SEARCH: begin
					// walk back from the tail for the newest move
					if (search_found) begin
						cnt_q  <= pidx_q + LVL_W'(1);
						pend_q <= 1'b0;
					end else if (search_fail) begin
						drop_q <= 1'b1;
					end else begin
						pend_q <= more_q;
						if (more_q) begin
							pidx_q <= cnt_q;
							if (cnt_q == '0) begin
								more_q <= 1'b0;
							end else begin
								cnt_q <= cnt_q - LVL_W'(1);
							end
						end
					end
				end
				ST_SHIFT: begin
					if (shift_done) begin
						acc_q    <= 1'b1;
						coal_q   <= 1'b1;
						queued_q <= 1'b1;
					end else begin
						pend_q <= (cnt_q != fill_q);
						if (cnt_q != fill_q) begin
							pidx_q <= cnt_q;
							cnt_q  <= cnt_q + LVL_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LVL_W'(QUEUE_DEPTH))
		else $error("fill level beyond queue depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st.done |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after result");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q != ST_IDLE))
		else $error("accepted request did not start the sequencer");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && (state_q == ST_IDLE)))
		else $error("slot write while idle");

	a_acc_drop: assert property (@(posedge clk) disable iff (!arst_n)
		st.done |-> !(st.accepted && st.inc_drop))
		else $error("report both accepted and dropped");
`endif

endmodule

[rtl/touch_event_coalescing_queue_top.sv]
// ----------------------------------------------------------------------------
// touch_event_coalescing_queue_top - bounded queue of touch reports
// Push, pop, cancel and clear requests with move coalescing on a full ring.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one result, shown on result for the single cycle in which done is
// high; the receiver cannot stall, so capture it then. All the work of a
// request goes through the one slot RAM port. Pop, cancel and clear go from
// idle to the head read and the report; a plain push first writes the new
// entry. A press near a full ring first scans every queued entry to count
// the moves (a refused press then skips the write). A push on a full ring
// reads the back entry, and a move onto a move there is merged into it; a
// press or release then adds the move search (from the back towards the head)
// and the shift of the later entries over the removed move, with the new
// entry written at the back.
// busy stays high until the sequencer returns to idle; the next request may
// be offered while done is high. Slots need no clearing after reset: only written entries are used.
// ----------------------------------------------------------------------------
module touch_event_coalescing_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tecq_pkg::request_t request,
	output logic               done,
	output tecq_pkg::result_t  result
);

	import tecq_pkg::*;

	logic             we;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	entry_t           wr_data;
	entry_t           rd_data;
	status_t          st;

	logic [CNT_W-1:0] dropped_q;
	logic [CNT_W-1:0] coalesced_q;
	logic [CNT_W-1:0] queued_q;
	logic [CNT_W-1:0] dropped_d;
	logic [CNT_W-1:0] coalesced_d;
	logic [CNT_W-1:0] queued_d;
	logic             done_q;
	result_t          result_q;

	// slot storage: one entry per ring position
	tecq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_slots (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tecq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.st      (st)
	);

	// advance the statistics; clear zeroes them all
	always_comb begin
		if (st.clr_cnt) begin
			dropped_d   = '0;
			coalesced_d = '0;
			queued_d    = '0;
		end else begin
			dropped_d   = dropped_q   + CNT_W'(st.inc_drop);
			coalesced_d = coalesced_q + CNT_W'(st.inc_coal);
			queued_d    = queued_q    + CNT_W'(st.inc_queued);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q   <= '0;
			coalesced_q <= '0;
			queued_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= st.done;
			if (st.done) begin
				dropped_q   <= dropped_d;
				coalesced_q <= coalesced_d;
				queued_q    <= queued_d;
			end
		end
	end

	// hold the result for its one strobe cycle; the sequencer is free meanwhile
	always_ff @(posedge clk) begin
		if (st.done) begin
			result_q.accepted        <= st.accepted;
			result_q.level_before    <= st.level_before;
			result_q.head_valid      <= st.head_valid;
			result_q.head_phase      <= st.head.phase;
			result_q.head_id         <= st.head.id;
			result_q.head_x          <= st.head.x;
			result_q.head_y          <= st.head.y;
			result_q.head_pressure   <= st.head.pressure;
			result_q.head_major      <= st.head.major;
			result_q.head_minor      <= st.head.minor;
			result_q.dropped_total   <= dropped_d;
			result_q.coalesced_total <= coalesced_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
